>>> rtl/core/dsm_pkg.sv
// Shared types and constants of the drum step sequencer and mixer.
package dsm_pkg;

  localparam int unsigned BTN_W     = 16;
  localparam int unsigned AUX_W     = 6;
  localparam int unsigned SMP_W     = 8;
  localparam int unsigned LEN_W     = 14;
  localparam int unsigned TEMPO_W   = 9;
  localparam int unsigned VOICE_W   = 3;
  localparam int unsigned DAC_W     = 12;
  localparam int unsigned BEAT_W    = 16;
  localparam int unsigned TARGET_W  = 15;
  localparam int unsigned MIX_W     = 13;
  localparam int unsigned NUM_LEN   = 6;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TEMPO_W-1:0] TEMPO_MIN   = 9'd1;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 9'd500;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 9'd100;

  // floor(1000 / (2 * tempo)) equals floor(500 / tempo).
  localparam logic [TEMPO_W-1:0] DIV_NUM   = 9'd500;
  localparam int unsigned        DIV_STEPS = TEMPO_W;
  localparam int unsigned        DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [DAC_W-1:0] DAC_MAX = '1;
  localparam logic [LEN_W-1:0] PTR_MAX = '1;

  localparam logic [LEN_W-1:0] LEN_RESET [NUM_LEN] =
    '{14'd5288, 14'd9911, 14'd3233, 14'd9623, 14'd11910, 14'd6821};

  // Function codes of an input item.
  localparam logic FUNC_SCAN  = 1'b0;
  localparam logic FUNC_AUDIO = 1'b1;

  // Auxiliary button bit positions.
  localparam int unsigned AUX_PAUSE = 0;
  localparam int unsigned AUX_CLEAR = 1;
  localparam int unsigned AUX_UP    = 2;
  localparam int unsigned AUX_DOWN  = 3;
  localparam int unsigned AUX_NEXT  = 4;
  localparam int unsigned AUX_PREV  = 5;

  typedef struct packed {
    logic capture;
    logic div_init;
    logic div_step;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/dsm_ctrl.sv
// Controller state machine of the drum step sequencer and mixer.
module dsm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_func_i,
  output logic             in_stall_o,
  input  dsm_pkg::status_t status_i,
  output dsm_pkg::cmd_t    cmd_o
);
  import dsm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture  = 1'b1;
          cmd_o.div_init = 1'b1;
          state_d = (in_func_i == FUNC_SCAN) ? ST_DIV : ST_EXEC;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/dsm_datapath.sv
// Datapath of the drum step sequencer and mixer: state, tempo divider, mixer, output register.
module dsm_datapath #(
  parameter int unsigned STEPS  = 16,
  parameter int unsigned VOICES = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dsm_pkg::cmd_t                     cmd_i,
  output dsm_pkg::status_t                  status_o,
  input  logic                              cfg_we_i,
  input  logic [dsm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dsm_pkg::LEN_W-1:0]         cfg_data_i,
  input  logic                              func_i,
  input  logic [dsm_pkg::BTN_W-1:0]         step_buttons_i,
  input  logic [dsm_pkg::AUX_W-1:0]         aux_buttons_i,
  input  logic [dsm_pkg::SMP_W-1:0]         sample_v0_i,
  input  logic [dsm_pkg::SMP_W-1:0]         sample_v1_i,
  input  logic [dsm_pkg::SMP_W-1:0]         sample_v2_i,
  input  logic [dsm_pkg::SMP_W-1:0]         sample_v3_i,
  input  logic [dsm_pkg::SMP_W-1:0]         sample_v4_i,
  input  logic [dsm_pkg::SMP_W-1:0]         sample_v5_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [dsm_pkg::BTN_W-1:0]         step_leds_o,
  output logic [dsm_pkg::VOICE_W-1:0]       voice_select_o,
  output logic [dsm_pkg::TEMPO_W-1:0]       tempo_now_o,
  output logic                              paused_o,
  output logic [dsm_pkg::DAC_W-1:0]         dac_out_o,
  output logic [dsm_pkg::LEN_W-1:0]         sample_index_o,
  output logic                              audio_active_o
);
  import dsm_pkg::*;

  localparam int unsigned CW = $clog2(STEPS + 1);

  // True when step i is the column that cursor position c points at.
  function automatic logic at_col(input logic [CW-1:0] c, input int unsigned i);
    return (c == CW'(i)) || ((i == 0) && (c == CW'(STEPS)));
  endfunction

  // Captured input item.
  logic             func_q;
  logic [BTN_W-1:0] step_q;
  logic [AUX_W-1:0] aux_q;
  logic [SMP_W-1:0] smp_q [NUM_LEN];

  // Configuration.
  logic [LEN_W-1:0] len_q [NUM_LEN];

  // Sequencer state.
  logic [STEPS-1:0]   pattern_q [VOICES];
  logic [STEPS-1:0]   pattern_d [VOICES];
  logic [STEPS-1:0]   prev_steps_q, prev_steps_d;
  logic [AUX_W-1:0]   prev_aux_q, prev_aux_d;
  logic [BEAT_W-1:0]  beat_count_q, beat_count_d;
  logic [TEMPO_W-1:0] tempo_q, tempo_d;
  logic [VOICE_W-1:0] voice_q, voice_d;
  logic               pause_q, pause_d;
  logic [CW-1:0]      cursor_q, cursor_d;
  logic [STEPS-1:0]   leds_q, leds_d;
  logic               playing_q, playing_d;
  logic [LEN_W-1:0]   ptr_q, ptr_d;

  // Tempo divider.
  logic [TEMPO_W-1:0]   div_rem_q;
  logic [TEMPO_W-1:0]   div_quo_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [TEMPO_W:0]     div_trial;

  // Output register.
  logic               out_valid_q;
  logic [BTN_W-1:0]   out_leds_q;
  logic [VOICE_W-1:0] out_voice_q;
  logic [TEMPO_W-1:0] out_tempo_q;
  logic               out_pause_q;
  logic [DAC_W-1:0]   out_dac_q;
  logic [LEN_W-1:0]   out_ptr_q;
  logic               out_play_q;

  logic [STEPS-1:0]   steps_w;
  logic [STEPS-1:0]   view_w;
  logic [BTN_W-1:0]   leds_w;
  logic [LEN_W-1:0]   vlen [VOICES];
  logic [SMP_W-1:0]   vsmp [VOICES];
  logic [DAC_W-1:0]   dac_d;

  if (STEPS <= BTN_W) begin : g_steps_narrow
    assign steps_w = step_q[STEPS-1:0];
    assign leds_w  = {{(BTN_W - STEPS){1'b0}}, view_w};
  end else begin : g_steps_wide
    assign steps_w = {{(STEPS - BTN_W){1'b0}}, step_q};
    assign leds_w  = view_w[BTN_W-1:0];
  end

  // Voices without a sound slot play nothing and have length zero.
  for (genvar v = 0; v < VOICES; v++) begin : g_voice
    if (v < NUM_LEN) begin : g_real
      assign vlen[v] = len_q[v];
      assign vsmp[v] = smp_q[v];
    end else begin : g_none
      assign vlen[v] = '0;
      assign vsmp[v] = '0;
    end
  end

  assign div_trial = {div_rem_q, div_quo_q[TEMPO_W-1]};

  assign status_o.div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    logic [TARGET_W-1:0] target;
    logic [BEAT_W-1:0]   cnt_inc;
    logic [AUX_W-1:0]    edges;
    logic                beat;
    logic                play_any;
    logic [STEPS-1:0]    col_mask;
    logic [TEMPO_W-1:0]  tempo_up;
    logic [VOICE_W-1:0]  voice_nx;
    logic [MIX_W-1:0]    sum;

    // Beat target: quotient times 60, done as times 64 minus times 4.
    target   = (TARGET_W'(div_quo_q) << 6) - (TARGET_W'(div_quo_q) << 2);
    cnt_inc  = beat_count_q + BEAT_W'(1);
    edges    = aux_q & ~prev_aux_q;
    beat     = 1'b0;
    play_any = 1'b0;
    col_mask = '0;
    tempo_up = tempo_q;
    voice_nx = voice_q;
    sum      = '0;

    pattern_d    = pattern_q;
    prev_steps_d = prev_steps_q;
    prev_aux_d   = prev_aux_q;
    beat_count_d = beat_count_q;
    tempo_d      = tempo_q;
    voice_d      = voice_q;
    pause_d      = pause_q;
    cursor_d     = cursor_q;
    leds_d       = leds_q;
    playing_d    = playing_q;
    ptr_d        = ptr_q;
    dac_d        = '0;

    if (func_q == FUNC_SCAN) begin
      if (!pause_q) begin
        beat_count_d = cnt_inc;
        if (cnt_inc >= BEAT_W'(target)) begin
          beat_count_d = '0;
          beat = 1'b1;
        end
      end

      for (int unsigned v = 0; v < VOICES; v++) begin
        if (voice_q == VOICE_W'(v)) begin
          pattern_d[v] = pattern_q[v] ^ (steps_w & ~prev_steps_q);
        end
      end
      prev_steps_d = steps_w;
      prev_aux_d   = aux_q;

      if (edges[AUX_PAUSE]) begin
        pause_d = ~pause_q;
      end

      if (beat) begin
        for (int unsigned i = 0; i < STEPS; i++) begin
          if (at_col(cursor_q, i)) begin
            leds_d[i] = 1'b0;
          end
          if (cursor_q == CW'(i + 1)) begin
            leds_d[i] = 1'b1;
          end
        end
        cursor_d = (cursor_q == CW'(1)) ? CW'(STEPS) : cursor_q - CW'(1);
        for (int unsigned i = 0; i < STEPS; i++) begin
          col_mask[i] = at_col(cursor_d, i);
        end
        for (int unsigned v = 0; v < VOICES; v++) begin
          if ((pattern_d[v] & col_mask) != '0) begin
            play_any = 1'b1;
          end
        end
        playing_d = play_any;
        ptr_d     = '0;
      end

      if (edges[AUX_UP] && (tempo_q < TEMPO_MAX)) begin
        tempo_up = tempo_q + TEMPO_W'(1);
      end
      tempo_d = tempo_up;
      if (edges[AUX_DOWN] && (tempo_up > TEMPO_MIN)) begin
        tempo_d = tempo_up - TEMPO_W'(1);
      end

      if (edges[AUX_NEXT]) begin
        voice_nx = (({1'b0, voice_q} + 4'd1) >= 4'(VOICES)) ? '0 : voice_q + VOICE_W'(1);
      end
      voice_d = voice_nx;
      if (edges[AUX_PREV]) begin
        voice_d = (voice_nx == '0) ? VOICE_W'(VOICES - 1) : voice_nx - VOICE_W'(1);
      end

      if (edges[AUX_CLEAR]) begin
        for (int unsigned v = 0; v < VOICES; v++) begin
          pattern_d[v] = '0;
        end
        prev_steps_d = '0;
        leds_d       = '0;
        cursor_d     = CW'(STEPS);
      end
    end else if (playing_q) begin
      for (int unsigned i = 0; i < STEPS; i++) begin
        col_mask[i] = at_col(cursor_q, i);
      end
      for (int unsigned v = 0; v < VOICES; v++) begin
        if ((pattern_q[v] & col_mask) != '0) begin
          if (ptr_q < vlen[v]) begin
            sum = sum + {{(MIX_W - SMP_W - 2){1'b0}}, vsmp[v], 2'b00};
          end else begin
            playing_d = 1'b0;
          end
        end
      end
      dac_d = (sum > MIX_W'(DAC_MAX)) ? DAC_MAX : sum[DAC_W-1:0];
      if (ptr_q < PTR_MAX) begin
        ptr_d = ptr_q + LEN_W'(1);
      end
    end
  end

  // Step LEDs of the item being finished: edited voice's pattern or the cursor light.
  always_comb begin
    view_w = leds_d;
    for (int unsigned v = 0; v < VOICES; v++) begin
      if (voice_d == VOICE_W'(v)) begin
        view_w = pattern_d[v] | leds_d;
      end
    end
  end

  // Item capture; payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      step_q   <= step_buttons_i;
      aux_q    <= aux_buttons_i;
      smp_q[0] <= sample_v0_i;
      smp_q[1] <= sample_v1_i;
      smp_q[2] <= sample_v2_i;
      smp_q[3] <= sample_v3_i;
      smp_q[4] <= sample_v4_i;
      smp_q[5] <= sample_v5_i;
    end
  end

  // Radix-2 restoring divider for 500 / tempo, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      div_rem_q <= '0;
      div_quo_q <= DIV_NUM;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      if (div_trial >= {1'b0, tempo_q}) begin
        div_rem_q <= TEMPO_W'(div_trial - {1'b0, tempo_q});
        div_quo_q <= {div_quo_q[TEMPO_W-2:0], 1'b1};
      end else begin
        div_rem_q <= div_trial[TEMPO_W-1:0];
        div_quo_q <= {div_quo_q[TEMPO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NUM_LEN; i++) begin
        len_q[i] <= LEN_RESET[i];
      end
    end else if (cfg_we_i) begin
      for (int unsigned i = 0; i < NUM_LEN; i++) begin
        if (cfg_index_i == CFG_IDX_W'(i)) begin
          len_q[i] <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned v = 0; v < VOICES; v++) begin
        pattern_q[v] <= '0;
      end
      prev_steps_q <= '0;
      prev_aux_q   <= '1;
      beat_count_q <= '0;
      tempo_q      <= TEMPO_RESET;
      voice_q      <= '0;
      pause_q      <= 1'b0;
      cursor_q     <= CW'(STEPS);
      leds_q       <= '0;
      playing_q    <= 1'b0;
      ptr_q        <= '0;
    end else if (cmd_i.exec) begin
      pattern_q    <= pattern_d;
      prev_steps_q <= prev_steps_d;
      prev_aux_q   <= prev_aux_d;
      beat_count_q <= beat_count_d;
      tempo_q      <= tempo_d;
      voice_q      <= voice_d;
      pause_q      <= pause_d;
      cursor_q     <= cursor_d;
      leds_q       <= leds_d;
      playing_q    <= playing_d;
      ptr_q        <= ptr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_leds_q  <= leds_w;
      out_voice_q <= voice_d;
      out_tempo_q <= tempo_d;
      out_pause_q <= pause_d;
      out_dac_q   <= dac_d;
      out_ptr_q   <= ptr_d;
      out_play_q  <= playing_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign step_leds_o    = out_leds_q;
  assign voice_select_o = out_voice_q;
  assign tempo_now_o    = out_tempo_q;
  assign paused_o       = out_pause_q;
  assign dac_out_o      = out_dac_q;
  assign sample_index_o = out_ptr_q;
  assign audio_active_o = out_play_q;

endmodule

>>> rtl/core/drum_step_sequencer_mixer_top.sv
// Top level of the drum step sequencer and mixer: controller, datapath and checks.
//
// Each item is one tick: a scan tick (func 0) carries the step and auxiliary
// button levels, an audio tick (func 1) carries one sample byte per voice. The
// item is captured at the edge that accepts it. A scan tick then passes through
// the radix-2 divider that forms the beat target floor(500 / tempo) * 60 from
// the current tempo, and then through the update step, which updates the
// sequencer state and loads the output register. An audio tick goes straight
// to the update step. The block holds one item at a time and takes the next
// item as soon as the previous one has reached the output register, even while
// that result still waits behind out_stall_i. The update step waits only while
// the output register holds a result that out_stall_i is still holding back.
// Voice lengths are written through cfg_we_i, cfg_index_i and cfg_data_i; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Indexes beyond the last voice are ignored.
module drum_step_sequencer_mixer_top #(
  parameter int unsigned STEPS  = 16,
  parameter int unsigned VOICES = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dsm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dsm_pkg::LEN_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic [dsm_pkg::BTN_W-1:0]         step_buttons_i,
  input  logic [dsm_pkg::AUX_W-1:0]         aux_buttons_i,
  input  logic [dsm_pkg::SMP_W-1:0]         sample_v0_i,
  input  logic [dsm_pkg::SMP_W-1:0]         sample_v1_i,
  input  logic [dsm_pkg::SMP_W-1:0]         sample_v2_i,
  input  logic [dsm_pkg::SMP_W-1:0]         sample_v3_i,
  input  logic [dsm_pkg::SMP_W-1:0]         sample_v4_i,
  input  logic [dsm_pkg::SMP_W-1:0]         sample_v5_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [dsm_pkg::BTN_W-1:0]         step_leds_o,
  output logic [dsm_pkg::VOICE_W-1:0]       voice_select_o,
  output logic [dsm_pkg::TEMPO_W-1:0]       tempo_now_o,
  output logic                              paused_o,
  output logic [dsm_pkg::DAC_W-1:0]         dac_out_o,
  output logic [dsm_pkg::LEN_W-1:0]         sample_index_o,
  output logic                              audio_active_o
);
  import dsm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller sequences capture, divider steps and the state update.
  dsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (func_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the patterns, counters, divider and output register.
  dsm_datapath #(
    .STEPS  (STEPS),
    .VOICES (VOICES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (func_i),
    .step_buttons_i (step_buttons_i),
    .aux_buttons_i  (aux_buttons_i),
    .sample_v0_i    (sample_v0_i),
    .sample_v1_i    (sample_v1_i),
    .sample_v2_i    (sample_v2_i),
    .sample_v3_i    (sample_v3_i),
    .sample_v4_i    (sample_v4_i),
    .sample_v5_i    (sample_v5_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .step_leds_o    (step_leds_o),
    .voice_select_o (voice_select_o),
    .tempo_now_o    (tempo_now_o),
    .paused_o       (paused_o),
    .dac_out_o      (dac_out_o),
    .sample_index_o (sample_index_o),
    .audio_active_o (audio_active_o)
  );

  // The state update never overwrites a result that is still waiting.
  a_exec_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> !(out_valid_o && out_stall_i))
    else $error("state update while the output register is held");

  // Once an item is taken, the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> in_stall_o)
    else $error("input not stalled after an item was taken");

  // The reported tempo stays inside its clamp range.
  a_tempo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((tempo_now_o >= TEMPO_MIN) && (tempo_now_o <= TEMPO_MAX)))
    else $error("tempo out of range");

  // The edited voice is always one of the configured voices.
  a_voice_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, voice_select_o} < (VOICE_W + 1)'(VOICES)))
    else $error("voice select out of range");

endmodule

>>> tb/sv/dsm_panel_checker.sv
// Checker for the drum step sequencer: predicts each result and compares it with the block.
`timescale 1ns / 100ps

module dsm_panel_checker #(
  parameter int unsigned STEPS  = 16,
  parameter int unsigned VOICES = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dsm_pkg::LEN_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          func_i,
  input  logic [dsm_pkg::BTN_W-1:0]     step_buttons_i,
  input  logic [dsm_pkg::AUX_W-1:0]     aux_buttons_i,
  input  logic [dsm_pkg::SMP_W-1:0]     sample_v0_i,
  input  logic [dsm_pkg::SMP_W-1:0]     sample_v1_i,
  input  logic [dsm_pkg::SMP_W-1:0]     sample_v2_i,
  input  logic [dsm_pkg::SMP_W-1:0]     sample_v3_i,
  input  logic [dsm_pkg::SMP_W-1:0]     sample_v4_i,
  input  logic [dsm_pkg::SMP_W-1:0]     sample_v5_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [dsm_pkg::BTN_W-1:0]     step_leds_i,
  input  logic [dsm_pkg::VOICE_W-1:0]   voice_select_i,
  input  logic [dsm_pkg::TEMPO_W-1:0]   tempo_now_i,
  input  logic                          paused_i,
  input  logic [dsm_pkg::DAC_W-1:0]     dac_out_i,
  input  logic [dsm_pkg::LEN_W-1:0]     sample_index_i,
  input  logic                          audio_active_i,
  output int                            fail_count_o,
  output int                            outstanding_o
);
  import dsm_pkg::*;

  localparam int unsigned BEAT_SCALE   = 60;
  localparam int unsigned MIX_GAIN     = 4;

  typedef struct packed {
    logic [BTN_W-1:0]   leds;
    logic [VOICE_W-1:0] voice;
    logic [TEMPO_W-1:0] tempo;
    logic               paused;
    logic [DAC_W-1:0]   dac;
    logic [LEN_W-1:0]   index;
    logic               active;
  } panel_t;

  // Shadow copy of the sequencer state and of the voice length registers.
  logic [LEN_W-1:0]   lengths [NUM_LEN];
  logic [BTN_W-1:0]   pattern [VOICES];
  logic [BTN_W-1:0]   steps_seen;
  logic [AUX_W-1:0]   aux_seen;
  logic [BEAT_W-1:0]  beat_count;
  logic [TEMPO_W-1:0] tempo;
  int unsigned        voice;
  logic               hold;
  int unsigned        cursor;
  logic [BTN_W-1:0]   cursor_leds;
  logic               playing;
  logic [LEN_W-1:0]   sample_ptr;

  panel_t panel_q [$];
  panel_t want;
  int     results_seen;

  task automatic report_mismatch(input string what);
    fail_count_o++;
    $display("dsm_panel_checker: result %0d %s", results_seen, what);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned exp_val);
    if (got != exp_val) begin
      report_mismatch($sformatf("%s: got %0d, want %0d", name, got, exp_val));
    end
  endtask

  function automatic panel_t run_sequencer(input logic fn, input logic [BTN_W-1:0] steps,
                                           input logic [AUX_W-1:0] aux,
                                           input logic [NUM_LEN*SMP_W-1:0] smp);
    logic [AUX_W-1:0] rise;
    logic             beat;
    int unsigned      beat_target;
    int unsigned      col;
    int unsigned      mix;
    panel_t           p;
    p   = '0;
    mix = 0;
    if (fn == FUNC_SCAN) begin
      rise        = aux & ~aux_seen;
      beat        = 1'b0;
      beat_target = (1000 / (2 * tempo)) * BEAT_SCALE;
      if (!hold) begin
        beat_count = beat_count + 1'b1;
        if (beat_count >= beat_target) begin
          beat_count = '0;
          beat       = 1'b1;
        end
      end
      pattern[voice] = pattern[voice] ^ (steps & ~steps_seen);
      steps_seen     = steps;
      aux_seen       = aux;
      if (rise[AUX_PAUSE]) hold = !hold;
      if (beat) begin
        // The light of the old cursor goes off and the next one down comes on.
        if (cursor == STEPS) cursor_leds[0] = 1'b0;
        else cursor_leds[cursor] = 1'b0;
        cursor_leds[cursor - 1] = 1'b1;
        cursor = cursor - 1;
        if (cursor == 0) cursor = STEPS;
        col     = (cursor == STEPS) ? 0 : cursor;
        playing = 1'b0;
        for (int v = 0; v < VOICES; v++) begin
          if (pattern[v][col]) playing = 1'b1;
        end
        sample_ptr = '0;
      end
      if (rise[AUX_UP] && tempo < TEMPO_MAX) tempo = tempo + 1'b1;
      if (rise[AUX_DOWN] && tempo > TEMPO_MIN) tempo = tempo - 1'b1;
      if (rise[AUX_NEXT]) voice = (voice == VOICES - 1) ? 0 : voice + 1;
      if (rise[AUX_PREV]) voice = (voice == 0) ? VOICES - 1 : voice - 1;
      if (rise[AUX_CLEAR]) begin
        for (int v = 0; v < VOICES; v++) pattern[v] = '0;
        steps_seen  = '0;
        cursor_leds = '0;
        cursor      = STEPS;
      end
    end else if (playing) begin
      col = (cursor == STEPS) ? 0 : cursor;
      for (int v = 0; v < VOICES; v++) begin
        if (pattern[v][col]) begin
          if (v < NUM_LEN && sample_ptr < lengths[v]) mix += smp[v*SMP_W +: SMP_W] * MIX_GAIN;
          else playing = 1'b0;
        end
      end
      p.dac = (mix > DAC_MAX) ? DAC_MAX : DAC_W'(mix);
      if (sample_ptr != PTR_MAX) sample_ptr = sample_ptr + 1'b1;
    end
    p.leds   = pattern[voice] | cursor_leds;
    p.voice  = VOICE_W'(voice);
    p.tempo  = tempo;
    p.paused = hold;
    p.index  = sample_ptr;
    p.active = playing;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NUM_LEN; v++) lengths[v] = LEN_RESET[v];
      for (int v = 0; v < VOICES; v++) pattern[v] = '0;
      steps_seen   = '0;
      aux_seen     = '1;
      beat_count   = '0;
      tempo        = TEMPO_RESET;
      voice        = 0;
      hold         = 1'b0;
      cursor       = STEPS;
      cursor_leds  = '0;
      playing      = 1'b0;
      sample_ptr   = '0;
      results_seen = 0;
      panel_q.delete();
    end else begin
      if (cfg_we_i && cfg_index_i < NUM_LEN) lengths[cfg_index_i] = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        panel_q.push_back(run_sequencer(func_i, step_buttons_i, aux_buttons_i,
                                        {sample_v5_i, sample_v4_i, sample_v3_i,
                                         sample_v2_i, sample_v1_i, sample_v0_i}));
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (panel_q.size() == 0) begin
          report_mismatch("arrived with no item waiting for it");
        end else begin
          want = panel_q.pop_front();
          check_field("step_leds", step_leds_i, want.leds);
          check_field("voice_select", voice_select_i, want.voice);
          check_field("tempo_now", tempo_now_i, want.tempo);
          check_field("paused", paused_i, want.paused);
          check_field("dac_out", dac_out_i, want.dac);
          check_field("sample_index", sample_index_i, want.index);
          check_field("audio_active", audio_active_i, want.active);
        end
      end
    end
    outstanding_o = panel_q.size();
  end

endmodule

>>> tb/sv/tb_drum_step_sequencer_mixer_top.sv
// Testbench top of the drum step sequencer and mixer: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_drum_step_sequencer_mixer_top;
  import dsm_pkg::*;

  // Each side idles at random with a chance of 31 percent unless the calm flag is set.
  localparam int unsigned IDLE_PCT      = 31;
  // More quiet cycles than a scan tick spends inside the block, so they leave it idle.
  localparam int unsigned SETTLE_CYCLES = 16;
  // The slowest correct run stays well under this limit.
  localparam int unsigned RUN_LIMIT     = 1_000_000;
  localparam int unsigned REG_LENGTH0   = 0;

  localparam logic [AUX_W-1:0] PRESS_PAUSE = AUX_W'(1) << AUX_PAUSE;
  localparam logic [AUX_W-1:0] PRESS_CLEAR = AUX_W'(1) << AUX_CLEAR;
  localparam logic [AUX_W-1:0] PRESS_UP    = AUX_W'(1) << AUX_UP;
  localparam logic [AUX_W-1:0] PRESS_DOWN  = AUX_W'(1) << AUX_DOWN;
  localparam logic [AUX_W-1:0] PRESS_NEXT  = AUX_W'(1) << AUX_NEXT;
  localparam logic [AUX_W-1:0] PRESS_PREV  = AUX_W'(1) << AUX_PREV;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [LEN_W-1:0]     cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 func_i         = FUNC_SCAN;
  logic [BTN_W-1:0]     step_buttons_i = '0;
  logic [AUX_W-1:0]     aux_buttons_i  = '0;
  logic [SMP_W-1:0]     sample_v0_i    = '0;
  logic [SMP_W-1:0]     sample_v1_i    = '0;
  logic [SMP_W-1:0]     sample_v2_i    = '0;
  logic [SMP_W-1:0]     sample_v3_i    = '0;
  logic [SMP_W-1:0]     sample_v4_i    = '0;
  logic [SMP_W-1:0]     sample_v5_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [BTN_W-1:0]     step_leds_o;
  logic [VOICE_W-1:0]   voice_select_o;
  logic [TEMPO_W-1:0]   tempo_now_o;
  logic                 paused_o;
  logic [DAC_W-1:0]     dac_out_o;
  logic [LEN_W-1:0]     sample_index_o;
  logic                 audio_active_o;

  int          fail_count;
  int          outstanding;
  int unsigned cycle_count = 0;

  // When calm is set neither side idles; the playback at the end runs that way.
  bit               calm       = 1'b0;
  // The stimulus mirrors the block's edge detection so it knows whether the block is
  // paused. The auxiliary history starts at all ones, exactly as the block's does.
  logic [AUX_W-1:0] aux_last   = '1;
  bit               pause_on   = 1'b0;
  logic [BTN_W-1:0] held_steps = '0;

  drum_step_sequencer_mixer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .step_buttons_i (step_buttons_i),
    .aux_buttons_i  (aux_buttons_i),
    .sample_v0_i    (sample_v0_i),
    .sample_v1_i    (sample_v1_i),
    .sample_v2_i    (sample_v2_i),
    .sample_v3_i    (sample_v3_i),
    .sample_v4_i    (sample_v4_i),
    .sample_v5_i    (sample_v5_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .step_leds_o    (step_leds_o),
    .voice_select_o (voice_select_o),
    .tempo_now_o    (tempo_now_o),
    .paused_o       (paused_o),
    .dac_out_o      (dac_out_o),
    .sample_index_o (sample_index_o),
    .audio_active_o (audio_active_o)
  );

  dsm_panel_checker u_panel_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .func_i         (func_i),
    .step_buttons_i (step_buttons_i),
    .aux_buttons_i  (aux_buttons_i),
    .sample_v0_i    (sample_v0_i),
    .sample_v1_i    (sample_v1_i),
    .sample_v2_i    (sample_v2_i),
    .sample_v3_i    (sample_v3_i),
    .sample_v4_i    (sample_v4_i),
    .sample_v5_i    (sample_v5_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .step_leds_i    (step_leds_o),
    .voice_select_i (voice_select_o),
    .tempo_now_i    (tempo_now_o),
    .paused_i       (paused_o),
    .dac_out_i      (dac_out_o),
    .sample_index_i (sample_index_o),
    .audio_active_i (audio_active_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // The receiver stalls at random on the falling edge, the same way the sender idles.
  always @(negedge clk_i) begin
    out_stall_i = !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: a correct run never gets near this many cycles.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb_drum_step_sequencer_mixer_top NOT OK");
      $finish;
    end
  end

  // Sample bytes: mostly random, sometimes all at full scale to hit the mixer's
  // saturation, sometimes all zero.
  function automatic logic [NUM_LEN*SMP_W-1:0] random_samples();
    logic [NUM_LEN*SMP_W-1:0] s;
    int unsigned              pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      s = '1;
    end else if (pick < 20) begin
      s = '0;
    end else begin
      for (int v = 0; v < NUM_LEN; v++) s[v*SMP_W +: SMP_W] = SMP_W'($urandom);
    end
    return s;
  endfunction

  // Occasional button presses beside the main activity. Clear is kept rare so that
  // patterns survive long enough to be played.
  function automatic logic [AUX_W-1:0] stray_aux(input bit with_tempo);
    logic [AUX_W-1:0] a;
    a            = '0;
    a[AUX_PAUSE] = ($urandom_range(99) < 3);
    a[AUX_CLEAR] = ($urandom_range(99) < 2);
    a[AUX_NEXT]  = ($urandom_range(99) < 8);
    a[AUX_PREV]  = ($urandom_range(99) < 8);
    if (with_tempo) begin
      a[AUX_UP]   = ($urandom_range(99) < 8);
      a[AUX_DOWN] = ($urandom_range(99) < 8);
    end
    return a;
  endfunction

  // Presents one item, called and returning at a falling edge. Valid stays high after
  // acceptance, so back-to-back items need no second assignment in the same step.
  task automatic send_tick(input logic fn, input logic [BTN_W-1:0] steps,
                           input logic [AUX_W-1:0] aux,
                           input logic [NUM_LEN*SMP_W-1:0] smp);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    func_i         = fn;
    step_buttons_i = steps;
    aux_buttons_i  = aux;
    {sample_v5_i, sample_v4_i, sample_v3_i, sample_v2_i, sample_v1_i, sample_v0_i} = smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic scan(input logic [BTN_W-1:0] steps, input logic [AUX_W-1:0] aux);
    if (aux[AUX_PAUSE] && !aux_last[AUX_PAUSE]) pause_on = !pause_on;
    aux_last = aux;
    send_tick(FUNC_SCAN, steps, aux, random_samples());
  endtask

  // Audio ticks carry random button levels, which the block must ignore.
  task automatic audio(input logic [NUM_LEN*SMP_W-1:0] smp);
    send_tick(FUNC_AUDIO, BTN_W'($urandom), AUX_W'($urandom), smp);
  endtask

  // Lets every result drain and the block go quiet before a register write or the end.
  task automatic settle();
    in_valid_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [LEN_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = CFG_IDX_W'(idx);
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Walks the tempo with press and release pairs on one button, with audio ticks,
  // step presses and stray buttons mixed in.
  task automatic ramp_tempo(input int unsigned presses, input logic [AUX_W-1:0] button);
    repeat (presses) begin
      while ($urandom_range(99) < 25) audio(random_samples());
      if ($urandom_range(99) < 20) held_steps = BTN_W'($urandom);
      scan(held_steps, stray_aux(1'b0) | button);
      scan(held_steps, stray_aux(1'b0));
    end
  endtask

  // Leaves the block running with every step of every voice set: unpause if needed,
  // clear, then for each voice press all step buttons and move to the next voice.
  task automatic fill_patterns();
    if (pause_on) begin
      scan('0, '0);
      scan('0, PRESS_PAUSE);
    end
    scan('0, '0);
    scan('0, PRESS_CLEAR);
    repeat (VOICE_W'(6)) begin
      scan('1, '0);
      scan('0, PRESS_NEXT);
    end
    scan('0, '0);
    held_steps = '0;
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, with the reset lengths. An audio tick before any beat gives silence,
    // and the all-ones auxiliary history means the first release shows no edge.
    audio('1);
    scan('0, '0);
    scan('1, '0);
    // Every auxiliary edge at once: pause, tempo up then down, voice next then prev, clear.
    scan('0, '1);
    scan('0, '0);
    scan(16'h8001, PRESS_UP);
    scan(16'h8001, '0);
    scan('0, PRESS_DOWN);
    scan('0, '0);
    scan('0, PRESS_UP | PRESS_DOWN);
    // Voice prev from voice 0 wraps to the last voice, next from there wraps back.
    scan('0, PRESS_PREV);
    scan('0, '0);
    scan('0, PRESS_NEXT);
    scan('0, PRESS_NEXT | PRESS_PREV);
    scan('0, '0);
    scan('0, PRESS_PAUSE);
    // Clear with a held step button: the button toggles again on the next scan tick.
    scan(16'h0004, PRESS_CLEAR);
    scan(16'h0004, '0);
    scan(16'hAAAA, '0);
    scan(16'h5555, '0);
    audio('0);
    audio({NUM_LEN{8'hA5}});

    // Tempo down to its floor of 1, still with the reset lengths.
    ramp_tempo(110, PRESS_DOWN);

    // Extreme lengths, including a voice that stops playback at once, plus writes to
    // the two indexes past the last voice, which the block ignores.
    settle();
    write_reg(REG_LENGTH0 + 0, '1);
    write_reg(REG_LENGTH0 + 1, '0);
    write_reg(REG_LENGTH0 + 2, LEN_W'(1));
    write_reg(REG_LENGTH0 + 3, LEN_W'($urandom));
    write_reg(REG_LENGTH0 + 4, LEN_W'($urandom));
    write_reg(REG_LENGTH0 + 5, LEN_W'(2));
    write_reg(REG_LENGTH0 + NUM_LEN, LEN_W'($urandom));
    write_reg(REG_LENGTH0 + NUM_LEN + 1, LEN_W'($urandom));

    // Tempo from 1 up past its ceiling of 500. While the target falls, the beat count
    // built up at slow tempos lies past it and the next counted tick takes the beat.
    ramp_tempo(520, PRESS_UP);

    // Short lengths so that voices run out within a few audio ticks of each beat and
    // the partial sums show, then a random mix at the fast tempo.
    settle();
    for (int r = 0; r < NUM_LEN; r++) write_reg(REG_LENGTH0 + r, LEN_W'($urandom_range(40)));
    fill_patterns();
    repeat (250) begin
      if ($urandom_range(99) < 45) begin
        audio(random_samples());
      end else begin
        if ($urandom_range(99) < 25) held_steps = BTN_W'($urandom);
        scan(held_steps, stray_aux(1'b1));
      end
    end

    // Playback with no idling on either side: all lengths at their maximum, every
    // step set, enough scan ticks for a beat at any tempo above 166, then a run of
    // audio ticks that mix all six voices together.
    settle();
    calm = 1'b1;
    for (int r = 0; r < NUM_LEN; r++) write_reg(REG_LENGTH0 + r, '1);
    fill_patterns();
    repeat (130) scan('0, '0);
    repeat (80) audio(random_samples());

    settle();
    if (fail_count == 0) begin
      $display("tb_drum_step_sequencer_mixer_top OK");
    end else begin
      $display("tb_drum_step_sequencer_mixer_top NOT OK");
    end
    $finish;
  end

endmodule
